FILE: rtl/rse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_pkg
// Shared constants for the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package rse_pkg;

    // default bits per colour channel
    localparam int COLOUR_BITS_DEF = 10;

    // window is KERNEL_SIZE columns by KERNEL_SIZE rows
    localparam int KERNEL_SIZE = 3;

    // colour channels per pixel
    localparam int NUM_CHAN = 3;

endpackage
`default_nettype wire

FILE: rtl/rgb_sobel_edge_magnitude.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_sobel_edge_magnitude
// Sobel edge strength over a stream of RGB pixel columns, grey result
// copied into all three colour fields.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one column of three vertically
//   adjacent pixels per request. The block keeps the two previous columns;
//   the new column completes a 3x3 window, and every request gives exactly
//   one result on the output channel (o_valid / i_ready).
//   An accepted request is loaded into the window register, then moves
//   through the channel magnitude register to the output register,
//   which presents the result.
//   Throughput: one request per clock while the receiver takes results.
//   Reset clears the stored columns to zero, so the first two results see
//   black pixels in the missing columns; all stages come up empty.
//   When the receiver stalls, the result holds in the output register and
//   the stages behind it fill up; o_ready drops only once all three stages
//   hold a result, and rises again in the cycle the receiver takes one.
//   Divide by three of the channel sum is a reciprocal multiply.
// ----------------------------------------------------------------------------
module rgb_sobel_edge_magnitude
    import rse_pkg::*;
#(
    parameter int COLOUR_BITS = COLOUR_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [3*COLOUR_BITS-1:0] i_top_pixel,
    input  wire logic [3*COLOUR_BITS-1:0] i_middle_pixel,
    input  wire logic [3*COLOUR_BITS-1:0] i_bottom_pixel,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [3*COLOUR_BITS-1:0]      o_edge_pixel
);

    localparam int PIX_W    = NUM_CHAN * COLOUR_BITS;
    localparam int SUM_W    = COLOUR_BITS + 2;
    localparam int DIV_K    = SUM_W + 2;
    localparam int DIV_M    = ((2 ** DIV_K) + 2) / 3;
    localparam int DIV_M_W  = DIV_K - 1;
    localparam int PROD_W   = SUM_W + DIV_M_W;

    // window columns, index 0 oldest
    logic [PIX_W-1:0]       r_top [KERNEL_SIZE];
    logic [PIX_W-1:0]       r_mid [KERNEL_SIZE];
    logic [PIX_W-1:0]       r_bot [KERNEL_SIZE];
    logic                   r_win_vld;

    logic [COLOUR_BITS-1:0] r_mag [NUM_CHAN];
    logic                   r_mag_vld;

    logic [COLOUR_BITS-1:0] r_avg;
    logic                   r_out_vld;

    logic                   en_out, en_mag, en_win, in_take;
    logic [COLOUR_BITS-1:0] n_mag [NUM_CHAN];
    logic [SUM_W-1:0]       chan_sum;
    logic [PROD_W-1:0]      div_prod;

    // stage enables: a stage loads when it is empty or its content moves on
    assign en_out  = !r_out_vld || i_ready;
    assign en_mag  = !r_mag_vld || en_out;
    assign en_win  = !r_win_vld || en_mag;
    assign o_ready = en_win;
    assign in_take = i_valid && en_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_vld <= 1'b0;
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                r_top[k] <= '0;
                r_mid[k] <= '0;
                r_bot[k] <= '0;
            end
        end else begin
            if (en_win) begin
                r_win_vld <= i_valid;
            end
            if (in_take) begin
                for (int k = 0; k < KERNEL_SIZE - 1; k++) begin
                    r_top[k] <= r_top[k+1];
                    r_mid[k] <= r_mid[k+1];
                    r_bot[k] <= r_bot[k+1];
                end
                r_top[KERNEL_SIZE-1] <= i_top_pixel;
                r_mid[KERNEL_SIZE-1] <= i_middle_pixel;
                r_bot[KERNEL_SIZE-1] <= i_bottom_pixel;
            end
        end
    end

    for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_chan
        logic [KERNEL_SIZE-1:0][COLOUR_BITS-1:0] top_c, mid_c, bot_c;

        always_comb begin
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                top_c[k] = r_top[k][ch*COLOUR_BITS +: COLOUR_BITS];
                mid_c[k] = r_mid[k][ch*COLOUR_BITS +: COLOUR_BITS];
                bot_c[k] = r_bot[k][ch*COLOUR_BITS +: COLOUR_BITS];
            end
        end

        rse_channel_mag #(
            .COLOUR_BITS(COLOUR_BITS)
        ) u_mag (
            .i_top(top_c),
            .i_mid(mid_c),
            .i_bot(bot_c),
            .o_mag(n_mag[ch])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_vld <= 1'b0;
        end else if (en_mag) begin
            r_mag_vld <= r_win_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_mag) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_mag[c] <= n_mag[c];
            end
        end
    end

    // floor(sum / 3) as sum * ceil(2^K / 3) >> K, exact for sums below 2^SUM_W
    assign chan_sum = SUM_W'(r_mag[0]) + SUM_W'(r_mag[1]) + SUM_W'(r_mag[2]);
    assign div_prod = PROD_W'(chan_sum) * PROD_W'(DIV_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en_out) begin
            r_out_vld <= r_mag_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_avg <= div_prod[DIV_K +: COLOUR_BITS];
        end
    end

    assign o_valid      = r_out_vld;
    assign o_edge_pixel = {r_avg, r_avg, r_avg};

endmodule
`default_nettype wire

FILE: rtl/rse_channel_mag.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_channel_mag
// Sobel gx/gy magnitude of one colour channel over a 3x3 window, with each
// absolute sum clamped and the final sum clamped to the channel maximum.
// ----------------------------------------------------------------------------
module rse_channel_mag
    import rse_pkg::*;
#(
    parameter int COLOUR_BITS = COLOUR_BITS_DEF
) (
    // column 0 is the oldest, column KERNEL_SIZE-1 the newest
    input  wire logic [KERNEL_SIZE-1:0][COLOUR_BITS-1:0] i_top,
    input  wire logic [KERNEL_SIZE-1:0][COLOUR_BITS-1:0] i_mid,
    input  wire logic [KERNEL_SIZE-1:0][COLOUR_BITS-1:0] i_bot,
    output logic      [COLOUR_BITS-1:0]                  o_mag
);

    localparam int EXT_W = COLOUR_BITS + 2;
    localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'((2 ** COLOUR_BITS) - 1);

    logic [EXT_W-1:0]       pos_x, neg_x, pos_y, neg_y;
    logic [EXT_W-1:0]       abs_x, abs_y;
    logic [COLOUR_BITS-1:0] clip_x, clip_y;
    logic [COLOUR_BITS:0]   sum_xy;

    // gx: right column minus left column, middle row weighted by two
    assign pos_x = EXT_W'(i_top[2]) + (EXT_W'(i_mid[2]) << 1) + EXT_W'(i_bot[2]);
    assign neg_x = EXT_W'(i_top[0]) + (EXT_W'(i_mid[0]) << 1) + EXT_W'(i_bot[0]);
    // gy: top row minus bottom row, middle column weighted by two
    assign pos_y = EXT_W'(i_top[0]) + (EXT_W'(i_top[1]) << 1) + EXT_W'(i_top[2]);
    assign neg_y = EXT_W'(i_bot[0]) + (EXT_W'(i_bot[1]) << 1) + EXT_W'(i_bot[2]);

    assign abs_x = (pos_x >= neg_x) ? (pos_x - neg_x) : (neg_x - pos_x);
    assign abs_y = (pos_y >= neg_y) ? (pos_y - neg_y) : (neg_y - pos_y);

    assign clip_x = (abs_x > MAX_EXT) ? '1 : abs_x[COLOUR_BITS-1:0];
    assign clip_y = (abs_y > MAX_EXT) ? '1 : abs_y[COLOUR_BITS-1:0];

    assign sum_xy = (COLOUR_BITS + 1)'(clip_x) + (COLOUR_BITS + 1)'(clip_y);

    // carry out means the sum passed the channel maximum
    assign o_mag = sum_xy[COLOUR_BITS] ? '1 : sum_xy[COLOUR_BITS-1:0];

endmodule
`default_nettype wire

FILE: rtl/rse_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_checker
// Port-level checks for the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
module rse_checker
    import rse_pkg::*;
#(
    parameter int COLOUR_BITS = COLOUR_BITS_DEF
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_ready,
    input wire logic                     o_valid,
    input wire logic                     i_ready,
    input wire logic [3*COLOUR_BITS-1:0] o_edge_pixel
);

    // a stalled result stays presented
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_edge_pixel))
        else $error("result changed while stalled");

    // grey value copied into all three colour fields
    a_grey : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_edge_pixel[3*COLOUR_BITS-1:2*COLOUR_BITS] ==
             o_edge_pixel[2*COLOUR_BITS-1:COLOUR_BITS]) &&
            (o_edge_pixel[2*COLOUR_BITS-1:COLOUR_BITS] ==
             o_edge_pixel[COLOUR_BITS-1:0]))
        else $error("colour fields differ");

    // with nothing waiting at the output, the pipe cannot be full
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("request refused with empty output");

    // pipeline comes out of reset empty
    a_reset_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result presented right after reset");

endmodule

bind rgb_sobel_edge_magnitude rse_checker #(
    .COLOUR_BITS(COLOUR_BITS)
) u_rse_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_ready(o_ready),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_edge_pixel(o_edge_pixel)
);
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB Sobel edge magnitude block: random pixel
// column streams with random stalls on both sides, checked against a
// cycle-free model of the 3x3 window and grey edge strength.
// ----------------------------------------------------------------------------
module testbench;
    import rse_pkg::*;

    localparam int CB            = COLOUR_BITS_DEF;
    localparam int PIX_W         = NUM_CHAN * CB;
    localparam int COLOUR_MAX    = (1 << CB) - 1;
    localparam int CLK_PERIOD    = 10;
    localparam int TOTAL_COLUMNS = 1950;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_REPORTS   = 10;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [CB-1:0]    chan_t;

    localparam pixel_t PIX_MAX = '1;
    localparam chan_t  CH_MAX  = '1;
    localparam chan_t  CH_ZERO = '0;

    typedef struct packed {
        logic   drain;
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_req_t;

    typedef enum int {
        PAT_NOISE,
        PAT_SMOOTH,
        PAT_STEP,
        PAT_EXTREME,
        PAT_BITS
    } pattern_e;

    logic   i_clk          = 1'b0;
    logic   i_rst_n        = 1'b0;
    logic   i_valid        = 1'b0;
    logic   i_ready        = 1'b0;
    pixel_t i_top_pixel    = '0;
    pixel_t i_middle_pixel = '0;
    pixel_t i_bottom_pixel = '0;
    logic   o_ready;
    logic   o_valid;
    pixel_t o_edge_pixel;

    rgb_sobel_edge_magnitude #(
        .COLOUR_BITS (CB)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_top_pixel    (i_top_pixel),
        .i_middle_pixel (i_middle_pixel),
        .i_bottom_pixel (i_bottom_pixel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_edge_pixel   (o_edge_pixel)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    column_req_t column_q [$];
    pixel_t      expected_edges [$];

    // model copy of the two stored columns, rows top/middle/bottom
    pixel_t win_prev [3];
    pixel_t win_old  [3];

    column_req_t head;
    pixel_t      want;
    logic        req_taken        = 1'b0;
    int          send_gap         = 0;
    int          tx_burst         = 0;
    int          rx_burst         = 0;
    int          hold_left        = 0;
    int          rx_pick          = 0;
    bit          long_hold_done   = 1'b0;
    int          cycle_cnt        = 0;
    int          columns_sent     = 0;
    int          edges_checked    = 0;
    int          error_count      = 0;
    int          saturated_seen   = 0;
    int          zero_seen        = 0;
    int          in_stall_cycles  = 0;

    function automatic int clamp_mag(int v);
        int m;
        m = (v < 0) ? -v : v;
        return (m > COLOUR_MAX) ? COLOUR_MAX : m;
    endfunction

    // window: column 0 oldest, column 2 the new one; updates the stored columns
    function automatic pixel_t sobel_grey(pixel_t top, pixel_t mid, pixel_t bot);
        pixel_t col_new [3];
        int     p [3][3];
        int     gx, gy, mag, total;
        chan_t  grey;
        col_new[0] = top;
        col_new[1] = mid;
        col_new[2] = bot;
        total = 0;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            for (int r = 0; r < 3; r++) begin
                p[r][0] = int'(win_old[r][ch*CB +: CB]);
                p[r][1] = int'(win_prev[r][ch*CB +: CB]);
                p[r][2] = int'(col_new[r][ch*CB +: CB]);
            end
            gx = (p[0][2] - p[0][0]) + 2 * (p[1][2] - p[1][0]) + (p[2][2] - p[2][0]);
            gy = (p[0][0] + 2 * p[0][1] + p[0][2]) - (p[2][0] + 2 * p[2][1] + p[2][2]);
            mag = clamp_mag(gx) + clamp_mag(gy);
            if (mag > COLOUR_MAX) begin
                mag = COLOUR_MAX;
            end
            total += mag;
        end
        grey = chan_t'(total / 3);
        for (int r = 0; r < 3; r++) begin
            win_old[r]  = win_prev[r];
            win_prev[r] = col_new[r];
        end
        return {NUM_CHAN{grey}};
    endfunction

    // mostly zero, some short, a few long, and now and then a run of zeros
    function automatic int pick_gap(inout int burst);
        int roll;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            burst = $urandom_range(30, 120);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic pixel_t jitter(pixel_t base, int spread);
        pixel_t px;
        int     v;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            v = int'(base[ch*CB +: CB]) + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 0) v = 0;
            if (v > COLOUR_MAX) v = COLOUR_MAX;
            px[ch*CB +: CB] = chan_t'(v);
        end
        return px;
    endfunction

    function automatic pattern_e pick_pattern();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3) return PAT_NOISE;
        if (roll < 5) return PAT_SMOOTH;
        if (roll < 8) return PAT_STEP;
        if (roll < 9) return PAT_EXTREME;
        return PAT_BITS;
    endfunction

    // a few requests wait until the block has delivered everything
    task automatic add_column(pixel_t top, pixel_t mid, pixel_t bot);
        column_req_t req;
        req.drain = (column_q.size() == 400) || (column_q.size() == 1300) ||
                    ($urandom_range(0, 199) == 0);
        req.top   = top;
        req.mid   = mid;
        req.bot   = bot;
        column_q.push_back(req);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (column_q.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                head = column_q[0];
                if (head.drain && expected_edges.size() != 0) begin
                    i_valid <= 1'b0;
                end else begin
                    void'(column_q.pop_front());
                    i_valid        <= 1'b1;
                    i_top_pixel    <= head.top;
                    i_middle_pixel <= head.mid;
                    i_bottom_pixel <= head.bot;
                    send_gap = pick_gap(tx_burst);
                end
            end
        end
    end

    // result receiver, with one long hold-off once traffic is under way
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (!long_hold_done && edges_checked >= 700) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            rx_pick = pick_gap(rx_burst);
            if (rx_pick == 0) begin
                i_ready <= 1'b1;
            end else begin
                hold_left = rx_pick - 1;
                i_ready <= 1'b0;
            end
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && !o_ready) begin
                in_stall_cycles++;
            end
            if (i_valid && o_ready) begin
                expected_edges.push_back(sobel_grey(i_top_pixel, i_middle_pixel,
                                                    i_bottom_pixel));
                columns_sent++;
            end
            if (o_valid && i_ready) begin
                if (expected_edges.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: result %h with nothing expected", $realtime,
                                 o_edge_pixel);
                    end
                end else begin
                    want = expected_edges.pop_front();
                    edges_checked++;
                    if (want[CB-1:0] == CH_MAX) saturated_seen++;
                    if (want[CB-1:0] == CH_ZERO) zero_seen++;
                    if (o_edge_pixel !== want) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display("%0t: edge_pixel mismatch on result %0d: exp %h got %h",
                                     $realtime, edges_checked, want, o_edge_pixel);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending", cycle_cnt,
                     expected_edges.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        pattern_e kind;
        int       seg_len;
        int       edge_at;
        bit       horiz;
        bit       pick;
        pixel_t   a;
        pixel_t   b;
        pixel_t   px [3];

        for (int r = 0; r < 3; r++) begin
            win_prev[r] = '0;
            win_old[r]  = '0;
        end

        // start of stream against the zero reset columns, then flat, falling edge
        add_column(PIX_MAX, PIX_MAX, PIX_MAX);
        add_column(PIX_MAX, PIX_MAX, PIX_MAX);
        add_column(PIX_MAX, PIX_MAX, PIX_MAX);
        add_column('0, '0, '0);
        add_column('0, '0, '0);
        // horizontal edges both ways
        add_column(PIX_MAX, '0, '0);
        add_column('0, '0, PIX_MAX);
        // one channel at a time
        add_column({CH_MAX, CH_ZERO, CH_ZERO}, {CH_MAX, CH_ZERO, CH_ZERO},
                   {CH_MAX, CH_ZERO, CH_ZERO});
        add_column({CH_ZERO, CH_MAX, CH_ZERO}, {CH_ZERO, CH_MAX, CH_ZERO},
                   {CH_ZERO, CH_MAX, CH_ZERO});
        add_column({CH_ZERO, CH_ZERO, CH_MAX}, {CH_ZERO, CH_ZERO, CH_MAX},
                   {CH_ZERO, CH_ZERO, CH_MAX});
        // alternating bits and their mirror image
        add_column(30'h2AAAAAAA, 30'h15555555, 30'h2AAAAAAA);
        add_column(30'h15555555, 30'h2AAAAAAA, 30'h15555555);
        add_column('0, PIX_MAX, '0);
        add_column('0, '0, '0);
        // small values in every channel
        add_column({10'd1, 10'd2, 10'd3}, {10'd4, 10'd5, 10'd6}, {10'd7, 10'd8, 10'd9});

        while (column_q.size() < TOTAL_COLUMNS) begin
            kind    = pick_pattern();
            seg_len = $urandom_range(2, 40);
            edge_at = $urandom_range(0, seg_len);
            horiz   = $urandom_range(0, 1);
            a       = pixel_t'($urandom);
            b       = pixel_t'($urandom);
            for (int k = 0; k < seg_len && column_q.size() < TOTAL_COLUMNS; k++) begin
                for (int r = 0; r < 3; r++) begin
                    case (kind)
                        PAT_NOISE: begin
                            px[r] = pixel_t'($urandom);
                        end
                        PAT_SMOOTH: begin
                            px[r] = jitter(a, 8);
                        end
                        PAT_STEP: begin
                            pick  = (k >= edge_at) ^ (horiz && r == 0);
                            px[r] = pick ? jitter(b, 2) : jitter(a, 2);
                        end
                        PAT_EXTREME: begin
                            for (int ch = 0; ch < NUM_CHAN; ch++) begin
                                px[r][ch*CB +: CB] = ($urandom_range(0, 1) != 0) ? CH_MAX
                                                                                  : CH_ZERO;
                            end
                        end
                        default: begin
                            px[r] = pixel_t'(1) << $urandom_range(0, PIX_W - 1);
                            if ($urandom_range(0, 1) != 0) px[r] = ~px[r];
                        end
                    endcase
                end
                add_column(px[0], px[1], px[2]);
            end
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (column_q.size() != 0 || i_valid || expected_edges.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);

        $display("Streamed %0d pixel columns; %0d edge results checked (%0d saturated, %0d zero).",
                 columns_sent, edges_checked, saturated_seen, zero_seen);
        $display("Block held off input for %0d cycles; %0d mismatches, %0d results left over.",
                 in_stall_cycles, error_count, expected_edges.size());
        if (error_count == 0 && expected_edges.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
